### rtl/pnc_pkg.sv
// Package for the polygon normal and centroid block.
// Field widths, bus widths, term codes and controller/datapath structs.
// No dependencies.
`default_nettype none

package pnc_pkg;

  localparam int unsigned CoordBits      = 24;
  localparam int unsigned NormBits       = 56;
  localparam int unsigned MaxVerticesDef = 64;

  localparam int unsigned InDataW  = 3 * CoordBits;
  localparam int unsigned OutDataW = 3 * NormBits + 3 * CoordBits;

  // Newell term selects: x uses (y diff, z sum), y uses (z, x), z uses (x, y)
  localparam logic [1:0] TermX = 2'd0;
  localparam logic [1:0] TermY = 2'd1;
  localparam logic [1:0] TermZ = 2'd2;

  typedef struct packed {
    logic       keep;
    logic       ovf_set;
    logic       close_load;
    logic       issue;
    logic [1:0] term;
    logic       div_start;
    logic       div_step;
    logic       out_load;
  } pnc_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
  } pnc_status_t;

endpackage

`default_nettype wire

### rtl/pnc_ctrl.sv
// Controller for the polygon normal and centroid block.
// Sequences vertex intake, edge terms, closing edge, division and output.
// Depends on pnc_pkg.
`default_nettype none

module pnc_ctrl
  import pnc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        vertex_valid_i,
  input  wire logic        vertex_last_i,
  output logic             vertex_ready_o,
  input  wire pnc_status_t status_i,
  output pnc_cmd_t         cmd_o
);

  localparam int unsigned CntW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SumW    = CoordBits + CntW;
  localparam int unsigned DivCntW = $clog2(SumW);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EDGE     = 3'd1;
  localparam logic [2:0] S_CLOSE_LD = 3'd2;
  localparam logic [2:0] S_CLOSE    = 3'd3;
  localparam logic [2:0] S_DIV      = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  // three terms issued, then the multiply and accumulate pipeline drains
  localparam logic [2:0] StepIssueLast = 3'd2;
  localparam logic [2:0] StepLast      = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [2:0]         step_q, step_d;
  logic [DivCntW-1:0] div_q, div_d;
  logic               last_q, last_d;
  logic               accept;

  assign vertex_ready_o = (state_q == S_IDLE);
  assign accept         = vertex_valid_i && vertex_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    div_d   = div_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = vertex_last_i;
          step_d = '0;
          if (status_i.full) begin
            cmd_o.ovf_set = 1'b1;
            state_d = vertex_last_i ? S_CLOSE_LD : S_IDLE;
          end else begin
            cmd_o.keep = 1'b1;
            if (!status_i.empty) begin
              state_d = S_EDGE;
            end else begin
              state_d = vertex_last_i ? S_CLOSE_LD : S_IDLE;
            end
          end
        end
      end
      S_EDGE, S_CLOSE: begin
        cmd_o.issue = (step_q <= StepIssueLast);
        cmd_o.term  = step_q[1:0];
        step_d      = step_q + 3'd1;
        if (step_q == StepLast) begin
          step_d = '0;
          if (state_q == S_EDGE) begin
            state_d = last_q ? S_CLOSE_LD : S_IDLE;
          end else begin
            cmd_o.div_start = 1'b1;
            div_d   = '0;
            state_d = S_DIV;
          end
        end
      end
      S_CLOSE_LD: begin
        cmd_o.close_load = 1'b1;
        step_d  = '0;
        state_d = S_CLOSE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_d = div_q + DivCntW'(1);
        if (div_q == DivCntW'(SumW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      div_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      div_q   <= div_d;
      last_q  <= last_d;
    end
  end

endmodule

`default_nettype wire

### rtl/pnc_dpath.sv
// Datapath for the polygon normal and centroid block: vertex registers,
// shared Newell multiplier, accumulators, radix-2 dividers, output register.
// Depends on pnc_pkg.
`default_nettype none

module pnc_dpath
  import pnc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pnc_cmd_t            cmd_i,
  input  wire logic [InDataW-1:0]  vertex_i,
  output pnc_status_t              status_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_flag_o
);

  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SumW  = CoordBits + CntW;
  localparam int unsigned OpW   = CoordBits + 1;
  localparam int unsigned ProdW = 2 * OpW;

  logic signed [CoordBits-1:0] vin     [3];
  logic signed [CoordBits-1:0] first_q [3];
  logic signed [CoordBits-1:0] prev_q  [3];
  logic signed [CoordBits-1:0] ea_q    [3];
  logic signed [CoordBits-1:0] eb_q    [3];
  logic signed [SumW-1:0]      sum_q   [3];
  logic signed [NormBits-1:0]  normal_q[3];
  logic [CntW-1:0]             cnt_q;
  logic                        ovf_q;

  logic signed [OpW-1:0]   opd_d, ops_d, opd_q, ops_q;
  logic                    opv_q;
  logic [1:0]              opk_q;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    prodv_q;
  logic [1:0]              prodk_q;

  logic [CntW-1:0]       rem_q  [3];
  logic [SumW-1:0]       quo_q  [3];
  logic                  neg_q  [3];
  logic [CntW:0]         shifted[3];
  logic [CntW:0]         trial  [3];
  logic [CoordBits-1:0]  center [3];

  logic [OutDataW-1:0] out_data_q;
  logic                out_flag_q;
  logic                out_valid_q;

  logic signed [CoordBits-1:0] da, db, sa, sb;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign vin[i]     = vertex_i[i*CoordBits +: CoordBits];
    assign shifted[i] = {rem_q[i], quo_q[i][SumW-1]};
    assign trial[i]   = shifted[i] - {1'b0, cnt_q};
    assign center[i]  = neg_q[i] ? (~quo_q[i][CoordBits-1:0] + CoordBits'(1))
                                 : quo_q[i][CoordBits-1:0];
  end

  assign status_o.empty    = (cnt_q == '0);
  assign status_o.full     = (cnt_q == CntW'(MAX_VERTICES));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // operand select for one Newell term
  always_comb begin
    unique case (cmd_i.term)
      TermX: begin
        da = ea_q[1]; db = eb_q[1]; sa = ea_q[2]; sb = eb_q[2];
      end
      TermY: begin
        da = ea_q[2]; db = eb_q[2]; sa = ea_q[0]; sb = eb_q[0];
      end
      default: begin
        da = ea_q[0]; db = eb_q[0]; sa = ea_q[1]; sb = eb_q[1];
      end
    endcase
    opd_d  = {da[CoordBits-1], da} - {db[CoordBits-1], db};
    ops_d  = {sa[CoordBits-1], sa} + {sb[CoordBits-1], sb};
    prod_d = opd_q * ops_q;
  end

  always_ff @(posedge clk_i) begin
    opd_q   <= opd_d;
    ops_q   <= ops_d;
    opk_q   <= cmd_i.term;
    prod_q  <= prod_d;
    prodk_q <= opk_q;
    if (cmd_i.keep) begin
      for (int i = 0; i < 3; i++) begin
        if (cnt_q == '0) begin
          first_q[i] <= vin[i];
        end
        ea_q[i]   <= prev_q[i];
        eb_q[i]   <= vin[i];
        prev_q[i] <= vin[i];
      end
    end else if (cmd_i.close_load) begin
      for (int i = 0; i < 3; i++) begin
        ea_q[i] <= prev_q[i];
        eb_q[i] <= first_q[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.div_start) begin
        neg_q[i] <= sum_q[i][SumW-1];
        quo_q[i] <= sum_q[i][SumW-1] ? (~sum_q[i] + SumW'(1)) : sum_q[i];
        rem_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        rem_q[i] <= trial[i][CntW] ? shifted[i][CntW-1:0] : trial[i][CntW-1:0];
        quo_q[i] <= {quo_q[i][SumW-2:0], !trial[i][CntW]};
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= {center[2], center[1], center[0],
                     normal_q[2], normal_q[1], normal_q[0]};
      out_flag_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      opv_q       <= 1'b0;
      prodv_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]    <= '0;
        normal_q[i] <= '0;
      end
    end else begin
      opv_q   <= cmd_i.issue;
      prodv_q <= opv_q;
      if (cmd_i.out_load) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i]    <= '0;
          normal_q[i] <= '0;
        end
      end else begin
        if (cmd_i.ovf_set) begin
          ovf_q <= 1'b1;
        end
        if (cmd_i.keep) begin
          cnt_q <= cnt_q + CntW'(1);
          for (int i = 0; i < 3; i++) begin
            sum_q[i] <= sum_q[i] + {{(SumW-CoordBits){vin[i][CoordBits-1]}}, vin[i]};
          end
        end
        for (int i = 0; i < 3; i++) begin
          if (prodv_q && (prodk_q == 2'(i))) begin
            normal_q[i] <= normal_q[i] + {{(NormBits-ProdW){prod_q[ProdW-1]}}, prod_q};
          end
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_flag_o  = out_flag_q;

endmodule

`default_nettype wire

### rtl/polygon_normal_and_centroid_top.sv
// Top level of the polygon normal and centroid block (Newell normal).
// Joins pnc_ctrl and pnc_dpath; depends on pnc_pkg.
//
// Usage: vertices of one polygon enter on the s_axis channel, one per item,
// signed Q16.8, with tlast on the final vertex. One result item per polygon
// leaves on m_axis: the unnormalized 56-bit normal, the centroid (sum over
// count, truncated toward zero) and a too-many-vertices flag in tuser.
// Vertices beyond MAX_VERTICES are dropped and set that flag.
// Sequence: the first vertex and a dropped vertex need no edge terms; every
// other vertex runs 3 terms through one shared multiplier and drains the
// multiply/accumulate pipeline before the next vertex is taken. After the last
// vertex the closing edge runs the same way, the centroid comes from a
// one-bit-per-cycle divider over SUM_W = 24 + clog2(MAX_VERTICES+1) bits (31
// at the default), and the output register is loaded once it is free.
// Reset clears all sums, counts and the output valid; no item is pending.
// A stalled receiver holds the result in the output register while the next
// polygon's vertices are taken; a second result waits until it is free.
`default_nettype none

module polygon_normal_and_centroid_top
  import pnc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // vertex_x, vertex_y, vertex_z
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // normal_x, normal_y, normal_z, center_x, center_y, center_z
  output logic [OutDataW-1:0]      m_axis_tdata,
  // too_many_vertices
  output logic                     m_axis_tuser
);

  pnc_cmd_t    cmd;
  pnc_status_t status;

  pnc_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_valid_i (s_axis_tvalid),
    .vertex_last_i  (s_axis_tlast),
    .vertex_ready_o (s_axis_tready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  pnc_dpath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .vertex_i    (s_axis_tdata),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_flag_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### tb/polygon_normal_and_centroid_top_test.sv
// Testbench for polygon_normal_and_centroid_top: Newell normal and centroid per polygon.
// A scoreboard class predicts each face result; tasks drive the vertex stream and an initial block drives result ready.
// Depends on pnc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module polygon_normal_and_centroid_top_test
  import pnc_pkg::*;
();

  localparam int unsigned MaxVerts = MaxVerticesDef;
  localparam int          CoordMin = -8388608;
  localparam int          CoordMax = 8388607;

  typedef struct packed {
    logic signed [CoordBits-1:0] z;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] cz;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] cx;
    logic signed [NormBits-1:0]  nz;
    logic signed [NormBits-1:0]  ny;
    logic signed [NormBits-1:0]  nx;
  } face_result_t;

  typedef struct packed {
    logic         too_many;
    face_result_t data;
  } face_expect_t;

  class newell_scoreboard;
    vertex_t             first_vtx;
    vertex_t             prev_vtx;
    logic [NormBits-1:0] nx_acc, ny_acc, nz_acc;
    longint              sx, sy, sz;
    int unsigned         vtx_count;
    bit                  dropped;
    face_expect_t        pending_faces[$];
    int                  errors;
    int                  faces_checked;

    function new();
      errors = 0;
      faces_checked = 0;
      clear_face();
    endfunction

    function void clear_face();
      first_vtx = '0;
      prev_vtx = '0;
      nx_acc = '0;
      ny_acc = '0;
      nz_acc = '0;
      sx = 0;
      sy = 0;
      sz = 0;
      vtx_count = 0;
      dropped = 1'b0;
    endfunction

    // edge a -> b, products kept modulo 2^56
    function void add_edge(vertex_t a, vertex_t b);
      longint ax, ay, az, bx, by, bz;
      ax = a.x;
      ay = a.y;
      az = a.z;
      bx = b.x;
      by = b.y;
      bz = b.z;
      nx_acc += NormBits'((ay - by) * (az + bz));
      ny_acc += NormBits'((az - bz) * (ax + bx));
      nz_acc += NormBits'((ax - bx) * (ay + by));
    endfunction

    function void add_vertex(vertex_t v, bit last);
      face_expect_t f;
      if (vtx_count >= MaxVerts) begin
        dropped = 1'b1;
      end else begin
        if (vtx_count == 0) first_vtx = v;
        else add_edge(prev_vtx, v);
        prev_vtx = v;
        sx += longint'(v.x);
        sy += longint'(v.y);
        sz += longint'(v.z);
        vtx_count++;
      end
      if (!last) return;
      add_edge(prev_vtx, first_vtx);
      f.data.nx = nx_acc;
      f.data.ny = ny_acc;
      f.data.nz = nz_acc;
      f.data.cx = CoordBits'(sx / longint'(vtx_count));
      f.data.cy = CoordBits'(sy / longint'(vtx_count));
      f.data.cz = CoordBits'(sz / longint'(vtx_count));
      f.too_many = dropped;
      pending_faces.push_back(f);
      clear_face();
    endfunction

    function int pending();
      return pending_faces.size();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_face(logic [OutDataW-1:0] data, logic flag);
      face_result_t got;
      face_expect_t want;
      got = data;
      faces_checked++;
      if (pending_faces.size() == 0) begin
        $error("result item with no face pending");
        errors++;
        return;
      end
      want = pending_faces.pop_front();
      compare_field("normal_x", want.data.nx, got.nx);
      compare_field("normal_y", want.data.ny, got.ny);
      compare_field("normal_z", want.data.nz, got.nz);
      compare_field("center_x", want.data.cx, got.cx);
      compare_field("center_y", want.data.cy, got.cy);
      compare_field("center_z", want.data.cz, got.cz);
      compare_field("too_many_vertices", want.too_many, flag);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // vertex_x, vertex_y, vertex_z
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // normal_x, normal_y, normal_z, center_x, center_y, center_z
  logic [OutDataW-1:0] m_axis_tdata;
  // too_many_vertices
  logic                m_axis_tuser;

  newell_scoreboard sb = new();

  polygon_normal_and_centroid_top #(
    .MAX_VERTICES(MaxVerts)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_face(m_axis_tdata, m_axis_tuser);
    end
  end

  // result side: random stalls, ready bursts, one long hold-off
  initial begin
    int stall_left;
    int ready_left;
    int r;
    bit long_hold_done;
    stall_left = 0;
    ready_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && ready_left == 0) begin
        r = $urandom_range(0, 99);
        if (!long_hold_done && sb.faces_checked >= 12) begin
          stall_left = 500;
          long_hold_done = 1'b1;
        end else if (r < 50) ready_left = $urandom_range(1, 8);
        else if (r < 85) stall_left = $urandom_range(1, 3);
        else if (r < 95) stall_left = $urandom_range(10, 50);
        else ready_left = $urandom_range(50, 150);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        ready_left--;
      end
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic vertex_t mk_vertex(int x, int y, int z);
    vertex_t v;
    v.x = CoordBits'(x);
    v.y = CoordBits'(y);
    v.z = CoordBits'(z);
    return v;
  endfunction

  function automatic logic [CoordBits-1:0] rand_coord(int mode);
    int m;
    m = (mode == 3) ? $urandom_range(0, 2) : mode;
    case (m)
      0: return CoordBits'($urandom);
      1: return CoordBits'(int'($urandom_range(0, 4000)) - 2000);
      default: begin
        case ($urandom_range(0, 4))
          0: return CoordBits'(CoordMin);
          1: return CoordBits'(CoordMax);
          2: return '0;
          3: return '1;
          default: return CoordBits'(1);
        endcase
      end
    endcase
  endfunction

  task automatic send_vertex(vertex_t v, bit last, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.add_vertex(v, last);
  endtask

  task automatic wait_for_faces();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int face_no;
    int len;
    int mode;
    int r;
    bit quiet;
    vertex_t v;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-vertex faces: zero normal, centroid is the vertex
    send_vertex(mk_vertex(CoordMax, CoordMin, -1), 1'b1, 0);
    send_vertex(mk_vertex(0, 0, 0), 1'b1, next_gap());
    send_vertex(mk_vertex(-1, -1, -1), 1'b1, 0);
    // two vertices at opposite extremes
    send_vertex(mk_vertex(CoordMax, CoordMin, CoordMax), 1'b0, 0);
    send_vertex(mk_vertex(CoordMin, CoordMax, CoordMin), 1'b1, 0);
    // extreme triangle
    send_vertex(mk_vertex(CoordMin, CoordMin, CoordMin), 1'b0, next_gap());
    send_vertex(mk_vertex(CoordMax, CoordMax, CoordMax), 1'b0, 0);
    send_vertex(mk_vertex(CoordMin, CoordMax, 0), 1'b1, 0);
    // negative sums: centroid truncates toward zero
    send_vertex(mk_vertex(-1, -2, 1), 1'b0, 0);
    send_vertex(mk_vertex(-1, 0, 1), 1'b0, 0);
    send_vertex(mk_vertex(0, 0, -7), 1'b1, 0);
    // unit square in xy, both windings
    send_vertex(mk_vertex(0, 0, 0), 1'b0, 0);
    send_vertex(mk_vertex(256, 0, 0), 1'b0, 0);
    send_vertex(mk_vertex(256, 256, 0), 1'b0, 0);
    send_vertex(mk_vertex(0, 256, 0), 1'b1, 0);
    send_vertex(mk_vertex(0, 256, 0), 1'b0, 0);
    send_vertex(mk_vertex(256, 256, 0), 1'b0, 0);
    send_vertex(mk_vertex(256, 0, 0), 1'b0, 0);
    send_vertex(mk_vertex(0, 0, 0), 1'b1, 0);
    wait_for_faces();

    sent = 0;
    face_no = 0;
    while (sent < 750) begin
      case (face_no)
        2: len = MaxVerts;
        5: len = MaxVerts + 1;
        20: len = MaxVerts + 8;
        45: len = 1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 8) len = $urandom_range(1, 2);
          else if (r < 90) len = $urandom_range(3, 8);
          else if (r < 97) len = $urandom_range(9, 40);
          else len = $urandom_range(60, 70);
        end
      endcase
      if (face_no == 35) wait_for_faces();
      quiet = (face_no % 11 == 4);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        v.x = rand_coord(mode);
        v.y = rand_coord(mode);
        v.z = rand_coord(mode);
        send_vertex(v, k == len - 1, quiet ? 0 : next_gap());
        sent++;
      end
      face_no++;
    end

    wait_for_faces();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/pnc_pkg.sv
rtl/pnc_ctrl.sv
rtl/pnc_dpath.sv
rtl/polygon_normal_and_centroid_top.sv
tb/polygon_normal_and_centroid_top_test.sv
